>>> design/bsa_pkg.sv
// Shared types and constants for the bounding sphere accumulator.
// No dependencies; every design file imports this package.
package bsa_pkg;

  localparam int CRD_W  = 32;          // center coordinate width
  localparam int RAD_W  = 31;          // radius width
  localparam int DIF_W  = 33;          // coordinate difference width
  localparam int MUL_W  = 36;          // shared multiplier operand width
  localparam int HALF_W = 18;          // multiplier chunk width
  localparam int ACC_W  = 72;          // multiply accumulator width
  localparam int DSQ_W  = 66;          // squared distance width
  localparam int NUM_W  = 68;          // root / divide numerator width
  localparam int ROOT_W = 34;          // root and quotient width
  localparam int DIV_W  = 35;          // divisor and scale width
  localparam int REM_W  = 38;          // partial remainder width
  localparam int CNT_W  = 6;

  localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};

  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_mode_t;

  typedef enum logic {
    OP_MERGE = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef struct packed {
    logic start;
    logic accum;
  } mac_cmd_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_cmd_t;

endpackage

>>> design/bsa_mac.sv
// Shared multiply-accumulate unit: one 36x18 multiplier, two partial products.
// Depends on bsa_pkg.
module bsa_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  bsa_pkg::mac_cmd_t         cmd,
  input  logic [bsa_pkg::MUL_W-1:0] a,
  input  logic [bsa_pkg::MUL_W-1:0] b,
  output logic [bsa_pkg::ACC_W-1:0] acc,
  output logic                      done
);
  import bsa_pkg::*;

  logic [MUL_W-1:0]        ar;
  logic [MUL_W-1:0]        br;
  logic                    phase;
  logic                    busy;
  logic [HALF_W-1:0]       chunk;
  logic [MUL_W+HALF_W-1:0] prod;
  logic [ACC_W-1:0]        addend;

  // Select the low or high chunk of b and form the partial product
  always_comb begin
    chunk  = phase ? br[MUL_W-1:HALF_W] : br[HALF_W-1:0];
    prod   = ar * chunk;
    addend = phase ? {prod, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod};
  end

  // Latch operands, then accumulate two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        ar    <= a;
        br    <= b;
        busy  <= 1'b1;
        phase <= 1'b0;
        if (!cmd.accum) acc <= '0;
      end else if (busy) begin
        acc   <= acc + addend;
        phase <= ~phase;
        if (phase) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bsa_root_div.sv
// Shared bit-serial unit: integer square root or restoring division, one bit a cycle.
// Depends on bsa_pkg.
module bsa_root_div (
  input  logic                       clk,
  input  logic                       rst,
  input  bsa_pkg::ds_cmd_t           cmd,
  input  logic [bsa_pkg::NUM_W-1:0]  num,
  input  logic [bsa_pkg::DIV_W-1:0]  divisor,
  output logic [bsa_pkg::ROOT_W-1:0] q,
  output logic                       done
);
  import bsa_pkg::*;

  ds_mode_t         mode;
  logic [REM_W-1:0] rem;
  logic [NUM_W-1:0] sh;
  logic [DIV_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] remsh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // One root digit or quotient bit per cycle
  always_comb begin
    if (mode == DS_SQRT) begin
      remsh = {rem[REM_W-3:0], sh[NUM_W-1 -: 2]};
      trial = {2'b00, q, 2'b01};
    end else begin
      remsh = {rem[REM_W-2:0], sh[NUM_W-1]};
      trial = {{(REM_W-DIV_W){1'b0}}, dv};
    end
    ge = (remsh >= trial);
  end

  // Load, then iterate ROOT_W steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        mode <= cmd.mode;
        dv   <= divisor;
        q    <= '0;
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
        if (cmd.mode == DS_SQRT) begin
          rem <= '0;
          sh  <= num;
        end else begin
          rem <= {{(REM_W-(NUM_W-ROOT_W)){1'b0}}, num[NUM_W-1:ROOT_W]};
          sh  <= {num[ROOT_W-1:0], {(NUM_W-ROOT_W){1'b0}}};
        end
      end else if (busy) begin
        rem <= ge ? (remsh - trial) : remsh;
        q   <= {q[ROOT_W-2:0], ge};
        sh  <= (mode == DS_SQRT) ? {sh[NUM_W-3:0], 2'b00} : {sh[NUM_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bounding_sphere_accumulator_unit.sv
// Bounding sphere accumulator top level: sequencer, sphere state, output register.
// Depends on bsa_pkg, bsa_mac and bsa_root_div.
// A point inside the sphere or a contained merge needs no root; a point outside takes
// one 34-step root, and a general merge takes one root and three divides.
// Throughput: one item at a time; the next transfer is taken once the sequencer idles.
// Reset (synchronous, rst high) gives a zero sphere at the origin, no output pending.
module bounding_sphere_accumulator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic signed [31:0]        in_x,
  input  logic signed [31:0]        in_y,
  input  logic signed [31:0]        in_z,
  input  logic [30:0]               in_radius,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic [30:0]               out_radius,
  output logic                      grew
);
  import bsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_RSQ, S_ROOT,
    S_MULX, S_DIVX, S_MULY, S_DIVY, S_MULZ, S_DIVZ, S_FIN
  } state_t;

  state_t state;

  logic signed [CRD_W-1:0] cx, cy, cz;
  logic [RAD_W-1:0]        rr;
  logic signed [CRD_W-1:0] nx, ny, nz;
  logic [RAD_W-1:0]        nr;
  logic                    op;
  logic signed [CRD_W-1:0] px, py, pz;
  logic [RAD_W-1:0]        pr;
  logic signed [DIF_W-1:0] dx, dy, dz;
  logic signed [CRD_W-1:0] rd;
  logic [DSQ_W-1:0]        dsq;
  logic [ROOT_W-1:0]       len;
  logic [DIV_W-1:0]        scale;

  mac_cmd_t          mac_cmd;
  logic [MUL_W-1:0]  mac_a, mac_b;
  logic [ACC_W-1:0]  mac_acc;
  logic              mac_done;
  ds_cmd_t           ds_cmd;
  logic [ROOT_W-1:0] ds_q;
  logic              ds_done;

  logic              mac_go, ds_go;
  logic [DIF_W-1:0]  ax, ay, az;
  logic [RAD_W-1:0]  ard;
  logic [DIF_W-1:0]  mul_d;
  logic              rd_pos;
  logic [DIV_W:0]    scale_next;
  logic [ROOT_W+1:0] rsum;
  logic [DIV_W-1:0]  rhalf;
  logic              free_out;

  // Absolute differences, scale factor, merged radius and handshake signals
  always_comb begin
    ax     = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
    ay     = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
    az     = dz[DIF_W-1] ? DIF_W'(-dz) : DIF_W'(dz);
    ard    = rd[CRD_W-1] ? RAD_W'(-rd) : RAD_W'(rd);
    rd_pos = !rd[CRD_W-1] && (rd != '0);
    scale_next = {2'b00, ds_q} + {{(DIV_W+1-CRD_W){rd[CRD_W-1]}}, rd};
    rsum   = {2'b00, len} + {5'b0, rr} + {5'b0, pr};
    rhalf  = rsum[ROOT_W+1:1];
    free_out = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
  end

  // Route operands of the shared multiplier by step and form the unit commands
  always_comb begin
    case (state)
      S_SQY, S_MULY: mul_d = ay;
      S_SQZ, S_MULZ: mul_d = az;
      default:       mul_d = ax;
    endcase
    mac_a = {{(MUL_W-DIF_W){1'b0}}, mul_d};
    mac_b = {{(MUL_W-DIF_W){1'b0}}, mul_d};
    if (state == S_RSQ) begin
      mac_a = (op == OP_POINT) ? {{(MUL_W-RAD_W){1'b0}}, rr} : {{(MUL_W-RAD_W){1'b0}}, ard};
      mac_b = mac_a;
    end else if (state == S_MULX || state == S_MULY || state == S_MULZ) begin
      mac_b = {{(MUL_W-DIV_W){1'b0}}, scale};
    end
    mac_cmd.start = mac_go;
    mac_cmd.accum = (state == S_SQY) || (state == S_SQZ);
    ds_cmd.start  = ds_go;
    ds_cmd.mode   = (state == S_ROOT) ? DS_SQRT : DS_DIV;
  end

  bsa_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc),
    .done (mac_done)
  );

  bsa_root_div u_root_div (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ds_cmd),
    .num     ((state == S_ROOT) ? {2'b00, dsq} : mac_acc[NUM_W-1:0]),
    .divisor ({len, 1'b0}),
    .q       (ds_q),
    .done    (ds_done)
  );

  // Sequencer, sphere state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mac_go    <= 1'b0;
      ds_go     <= 1'b0;
      out_valid <= 1'b0;
      cx        <= '0;
      cy        <= '0;
      cz        <= '0;
      rr        <= '0;
    end else begin
      mac_go <= 1'b0;
      ds_go  <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= operation;
            px     <= in_x;
            py     <= in_y;
            pz     <= in_z;
            pr     <= in_radius;
            dx     <= {in_x[CRD_W-1], in_x} - {cx[CRD_W-1], cx};
            dy     <= {in_y[CRD_W-1], in_y} - {cy[CRD_W-1], cy};
            dz     <= {in_z[CRD_W-1], in_z} - {cz[CRD_W-1], cz};
            rd     <= {1'b0, in_radius} - {1'b0, rr};
            nx     <= cx;
            ny     <= cy;
            nz     <= cz;
            nr     <= rr;
            mac_go <= 1'b1;
            state  <= S_SQX;
          end
        end
        S_SQX: if (mac_done) begin
          mac_go <= 1'b1;
          state  <= S_SQY;
        end
        S_SQY: if (mac_done) begin
          mac_go <= 1'b1;
          state  <= S_SQZ;
        end
        S_SQZ: if (mac_done) begin
          dsq    <= mac_acc[DSQ_W-1:0];
          mac_go <= 1'b1;
          state  <= S_RSQ;
        end
        S_RSQ: if (mac_done) begin
          if (op == OP_MERGE) begin
            if ({{(ACC_W-DSQ_W){1'b0}}, dsq} <= mac_acc) begin
              // one sphere holds the other: keep the larger
              if (rd_pos) begin
                nx <= px;
                ny <= py;
                nz <= pz;
                nr <= pr;
              end
              state <= S_FIN;
            end else begin
              ds_go <= 1'b1;
              state <= S_ROOT;
            end
          end else if ({{(ACC_W-DSQ_W){1'b0}}, dsq} > mac_acc) begin
            ds_go <= 1'b1;
            state <= S_ROOT;
          end else begin
            state <= S_FIN;
          end
        end
        S_ROOT: if (ds_done) begin
          len   <= ds_q;
          scale <= scale_next[DIV_W-1:0];
          if (op == OP_POINT) begin
            nr    <= (ds_q > ROOT_W'(RADIUS_MAX)) ? RADIUS_MAX : ds_q[RAD_W-1:0];
            state <= S_FIN;
          end else begin
            mac_go <= 1'b1;
            state  <= S_MULX;
          end
        end
        S_MULX: if (mac_done) begin
          ds_go <= 1'b1;
          state <= S_DIVX;
        end
        S_DIVX: if (ds_done) begin
          nx     <= dx[DIF_W-1] ? cx - CRD_W'(ds_q) : cx + CRD_W'(ds_q);
          mac_go <= 1'b1;
          state  <= S_MULY;
        end
        S_MULY: if (mac_done) begin
          ds_go <= 1'b1;
          state <= S_DIVY;
        end
        S_DIVY: if (ds_done) begin
          ny     <= dy[DIF_W-1] ? cy - CRD_W'(ds_q) : cy + CRD_W'(ds_q);
          mac_go <= 1'b1;
          state  <= S_MULZ;
        end
        S_MULZ: if (mac_done) begin
          ds_go <= 1'b1;
          state <= S_DIVZ;
        end
        S_DIVZ: if (ds_done) begin
          nz    <= dz[DIF_W-1] ? cz - CRD_W'(ds_q) : cz + CRD_W'(ds_q);
          nr    <= (rhalf > DIV_W'(RADIUS_MAX)) ? RADIUS_MAX : rhalf[RAD_W-1:0];
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free, then commit and transfer
          if (free_out) begin
            cx         <= nx;
            cy         <= ny;
            cz         <= nz;
            rr         <= nr;
            out_x      <= nx;
            out_y      <= ny;
            out_z      <= nz;
            out_radius <= nr;
            grew       <= (nx != cx) || (ny != cy) || (nz != cz) || (nr != rr);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
